/* sv/sfs_pkg.sv */
// Shared types, constants and codes of the sprite frame sequencer.
package sfs_pkg;

    // Frame storage limit; frame indexes are 8 bits wide in any case.
    localparam int MAX_FRAMES = 256;
    localparam int FRAME_LIMIT_INT = (MAX_FRAMES < 256) ? MAX_FRAMES : 256;
    localparam logic [8:0] FRAME_LIMIT = 9'(FRAME_LIMIT_INT);

    // Position: 9 integer bits (up to 256.0) and 16 fraction bits.
    localparam int POS_W = 25;
    // Step: Q8.8 speed times Q2.16 time, shifted right by 8.
    localparam int PROD_W = 34;
    localparam int DELTA_W = 26;
    // Moved position in two's complement.
    localparam int SUM_W = 28;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MODE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EVENTS_ENABLED = 2'd3;

    localparam logic [8:0] FRAME_COUNT_RST = 9'd0;
    localparam logic [15:0] ANIM_SPEED_RST = 16'd4096;

    typedef enum logic [2:0] {
        OP_ADVANCE    = 3'd0,
        OP_GOTO_PLAY  = 3'd1,
        OP_GOTO_STOP  = 3'd2,
        OP_ARM_STOP   = 3'd3,
        OP_SET_PAUSE  = 3'd4,
        OP_SET_REPEAT = 3'd5,
        OP_SET_FRAME  = 3'd6
    } sfs_op_t;

    typedef struct packed {
        logic [8:0]  frame_count;
        logic [15:0] anim_speed;
        logic        reverse_mode;
        logic        events_enabled;
    } sfs_cfg_t;

    // Item as held in the input register, step already multiplied out.
    typedef struct packed {
        sfs_op_t            op;
        logic [DELTA_W-1:0] delta;
        logic               el_zero;
        logic [8:0]         goto_frame;
        logic               pause_value;
        logic signed [15:0] repeat_value;
    } sfs_item_t;

    typedef struct packed {
        logic       is_paused;
        logic       reached_target_event;
        logic       last_frame_event;
        logic       first_frame_event;
        logic       new_frame_event;
        logic [7:0] current_frame;
    } sfs_result_t;

endpackage

/* sv/sfs_in_stage.sv */
// Input register: unpacks the item and registers the scaled time step.
module sfs_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,
    input  logic [2:0]         s_tuser,
    input  logic [15:0]        anim_speed,
    input  logic               take,
    output logic               item_valid,
    output sfs_pkg::sfs_item_t item
);
    import sfs_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    sfs_item_t         item_reg;
    sfs_item_t         item_next;
    logic [PROD_W-1:0] prod;
    logic [17:0]       el;
    logic [8:0]        tgt;

    assign el = s_tdata[17:0];
    assign tgt = s_tdata[26:18];
    assign prod = PROD_W'(anim_speed) * PROD_W'(el);
    assign s_tready = !valid_reg || take;

    always_comb
    begin
        item_next.op = sfs_op_t'(s_tuser);
        item_next.delta = prod[PROD_W-1:8];
        item_next.el_zero = (el == 18'd0);
        item_next.goto_frame = (tgt == 9'd0) ? 9'd0 : tgt - 9'd1;
        item_next.pause_value = s_tdata[27];
        item_next.repeat_value = s_tdata[43:28];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

/* sv/sfs_update.sv */
// Sequencer state and the next-state logic applied to one item per cycle while take is high.
module sfs_update
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  sfs_pkg::sfs_item_t   item,
    input  sfs_pkg::sfs_cfg_t    cfg,
    output sfs_pkg::sfs_result_t result
);
    import sfs_pkg::*;

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [7:0]         index_reg;
    logic [7:0]         index_next;
    logic signed [15:0] repeats_reg;
    logic signed [15:0] repeats_next;
    logic               paused_reg;
    logic               paused_next;
    logic [7:0]         target_reg;
    logic [7:0]         target_next;
    logic               armed_reg;
    logic               armed_next;

    logic [8:0]         n;
    logic [7:0]         size;
    logic [POS_W-1:0]   endpos;
    logic [POS_W-1:0]   pos_c;
    logic [SUM_W-1:0]   sum;
    logic               neg;
    logic [10:0]        raw;
    logic [7:0]         land;
    logic               go_ok;
    logic [7:0]         set_frame;
    logic               ev_new;
    logic               ev_first;
    logic               ev_last;
    logic               ev_target;
    logic               rep_pos;

    assign n = (cfg.frame_count > FRAME_LIMIT) ? FRAME_LIMIT : cfg.frame_count;
    assign size = 8'(n - 9'd1);
    assign endpos = {n, 16'd0};
    assign pos_c = (pos_reg > endpos) ? endpos : pos_reg;
    assign sum = cfg.reverse_mode ? SUM_W'(pos_c) - SUM_W'(item.delta)
                                  : SUM_W'(pos_c) + SUM_W'(item.delta);
    assign neg = sum[SUM_W-1];
    assign raw = neg ? 11'd0 : sum[26:16];
    assign land = ({1'b0, target_reg} < n) ? target_reg : size;
    assign go_ok = (item.goto_frame < n);
    assign rep_pos = !repeats_reg[15] && (repeats_reg != 16'sd0);

    always_comb
    begin
        if (n == 9'd0)
        begin
            set_frame = 8'd0;
        end
        else if (item.goto_frame >= n)
        begin
            set_frame = size;
        end
        else
        begin
            set_frame = item.goto_frame[7:0];
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        index_next = index_reg;
        repeats_next = repeats_reg;
        paused_next = paused_reg;
        target_next = target_reg;
        armed_next = armed_reg;
        ev_new = 1'b0;
        ev_first = 1'b0;
        ev_last = 1'b0;
        ev_target = 1'b0;
        case (item.op)
            OP_ADVANCE:
            begin
                if (!(n < 9'd2 || paused_reg || item.el_zero || repeats_reg == 16'sd0))
                begin
                    if (armed_reg && raw == {3'd0, target_reg})
                    begin
                        // Land on the target frame and pause there.
                        armed_next = 1'b0;
                        index_next = land;
                        pos_next = {1'b0, land, 16'd0};
                        paused_next = 1'b1;
                        ev_target = 1'b1;
                    end
                    else if (!cfg.reverse_mode && sum[26:0] >= 27'(endpos))
                    begin
                        pos_next = '0;
                        index_next = 8'd0;
                        ev_first = 1'b1;
                        if (rep_pos)
                        begin
                            repeats_next = repeats_reg - 16'sd1;
                        end
                    end
                    else if (cfg.reverse_mode && neg)
                    begin
                        pos_next = endpos;
                        index_next = size;
                        ev_last = 1'b1;
                        if (rep_pos)
                        begin
                            repeats_next = repeats_reg - 16'sd1;
                        end
                    end
                    else
                    begin
                        pos_next = sum[POS_W-1:0];
                        index_next = (raw > {3'd0, size}) ? size : raw[7:0];
                    end
                end
            end
            OP_GOTO_PLAY, OP_GOTO_STOP:
            begin
                if (go_ok)
                begin
                    // Keep the fractional position when already on that frame.
                    if (item.goto_frame[7:0] != index_reg)
                    begin
                        index_next = item.goto_frame[7:0];
                        pos_next = {item.goto_frame, 16'd0};
                    end
                    paused_next = 1'b0;
                end
                if (item.op == OP_GOTO_STOP)
                begin
                    paused_next = 1'b1;
                end
            end
            OP_ARM_STOP:
            begin
                if (go_ok)
                begin
                    target_next = item.goto_frame[7:0];
                    armed_next = 1'b1;
                    paused_next = 1'b0;
                end
            end
            OP_SET_PAUSE:
            begin
                paused_next = item.pause_value;
            end
            OP_SET_REPEAT:
            begin
                repeats_next = item.repeat_value;
            end
            OP_SET_FRAME:
            begin
                index_next = set_frame;
                pos_next = {1'b0, set_frame, 16'd0};
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
        if (index_next != index_reg)
        begin
            ev_new = 1'b1;
        end
    end

    always_comb
    begin
        result.current_frame = index_next;
        result.new_frame_event = ev_new && cfg.events_enabled;
        result.first_frame_event = ev_first && cfg.events_enabled;
        result.last_frame_event = ev_last && cfg.events_enabled;
        result.reached_target_event = ev_target && cfg.events_enabled;
        result.is_paused = paused_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            index_reg <= 8'd0;
            repeats_reg <= -16'sd1;
            paused_reg <= 1'b0;
            target_reg <= 8'd0;
            armed_reg <= 1'b0;
        end
        else if (take)
        begin
            pos_reg <= pos_next;
            index_reg <= index_next;
            repeats_reg <= repeats_next;
            paused_reg <= paused_next;
            target_reg <= target_next;
            armed_reg <= armed_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(pos_reg) && $stable(index_reg) && $stable(repeats_reg))
        else $error("state changed without an item");

    a_target_pauses: assert property (@(posedge clk) disable iff (!rst_n)
        take && ev_target |=> paused_reg && !armed_reg)
        else $error("reached target did not pause and disarm");

    a_one_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ev_first && ev_last) && !(ev_target && (ev_first || ev_last)))
        else $error("conflicting wrap and target events");

    a_forever_holds: assert property (@(posedge clk) disable iff (!rst_n)
        take && repeats_reg[15] && item.op != OP_SET_REPEAT
        |=> repeats_reg == $past(repeats_reg))
        else $error("endless repetition counter changed");
`endif

endmodule

/* sv/sfs_out_stage.sv */
// Result register toward the output stream.
module sfs_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  sfs_pkg::sfs_result_t result,
    output logic                 take,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata
);
    import sfs_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    sfs_result_t result_reg;

    // Move an item when the result register is free or being drained.
    assign take = item_valid && (!valid_reg || m_tready);

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = {3'd0, result_reg};

endmodule

/* sv/sprite_frame_sequencer_core.sv */
// Top level of the sprite frame sequencer: configuration registers and stages.
//
// Channel  Dir  Handshake             Payload
// s_       in   s_tvalid/s_tready     s_tdata, s_tuser (operation)
// m_       out  m_tvalid/m_tready     m_tdata (frame, events, pause flag)
// cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// Sustained rate is one item per cycle unless the output stalls; an item passes
// the input register, then the result register. The step multiply precedes the
// input register; state update and result selection sit between both registers.
// rst_n clears state to frame 0, endless repetition, unpaused, no stop target.
// A stalled output holds the result register; the input register still takes
// one item while the result waits.
module sprite_frame_sequencer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [17:0] elapsed_time, [26:18] target_frame, [27] pause_value,
    // [43:28] repeat_value, [47:44] zero
    input  logic [47:0] s_tdata,
    // [2:0] operation
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] current_frame, [8] new_frame_event, [9] first_frame_event,
    // [10] last_frame_event, [11] reached_target_event, [12] is_paused, [15:13] zero
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sfs_pkg::*;

    sfs_cfg_t    cfg_reg;
    sfs_cfg_t    cfg_next;
    sfs_item_t   item;
    sfs_result_t result;
    logic        item_valid;
    logic        take;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_COUNT:    cfg_next.frame_count = cfg_data[8:0];
                CFG_ANIM_SPEED:     cfg_next.anim_speed = cfg_data;
                CFG_REVERSE_MODE:   cfg_next.reverse_mode = cfg_data[0];
                CFG_EVENTS_ENABLED: cfg_next.events_enabled = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_count <= FRAME_COUNT_RST;
            cfg_reg.anim_speed <= ANIM_SPEED_RST;
            cfg_reg.reverse_mode <= 1'b0;
            cfg_reg.events_enabled <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sfs_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .anim_speed (cfg_reg.anim_speed),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    sfs_update u_update
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

    sfs_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
